// File: hw/rtl/ddpm_pkg.sv
// shared types and constants for the differential drive pwm mixer
// no dependencies; every other file of the block refers to it by scoped names

package ddpm_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DUTY_W     = 16;
  localparam int DZ_W       = 15;
  localparam int SPEED_W    = 17;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PWM_NEUTRAL    = 3'd0,
    CFG_PWM_UPPER      = 3'd1,
    CFG_PWM_LOWER      = 3'd2,
    CFG_DEADZONE_LIMIT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
  } in_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
  } out_rsp_t;

  // duty mapping settings, spans kept as magnitude and sign
  typedef struct packed {
    logic [DUTY_W-1:0] neutral;
    logic [DUTY_W-1:0] span_up_mag;
    logic              span_up_neg;
    logic [DUTY_W-1:0] span_dn_mag;
    logic              span_dn_neg;
    logic [DZ_W-1:0]   deadzone;
  } duty_cfg_t;

endpackage

// File: hw/rtl/ddpm_cfg_regs.sv
// configuration registers of the mixer and the derived duty spans
// depends on ddpm_pkg

module ddpm_cfg_regs #(
  parameter int DUTY_BITS = 16,
  localparam int DWS = (DUTY_BITS < ddpm_pkg::DUTY_W) ? DUTY_BITS : ddpm_pkg::DUTY_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ddpm_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [ddpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ddpm_pkg::duty_cfg_t                 duty_cfg
);

  logic [DWS-1:0]            neutral_r;
  logic [DWS-1:0]            upper_r;
  logic [DWS-1:0]            lower_r;
  logic [ddpm_pkg::DZ_W-1:0] deadzone_r;

  logic signed [DWS:0] up_diff;
  logic signed [DWS:0] dn_diff;
  logic [DWS:0]        up_abs;
  logic [DWS:0]        dn_abs;

  logic [ddpm_pkg::DUTY_W-1:0] up_mag_r;
  logic [ddpm_pkg::DUTY_W-1:0] dn_mag_r;
  logic                        up_neg_r;
  logic                        dn_neg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r  <= DWS'(32'd32768);
      upper_r    <= DWS'(32'd65535);
      lower_r    <= '0;
      deadzone_r <= ddpm_pkg::DZ_W'(820);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ddpm_pkg::CFG_PWM_NEUTRAL:    neutral_r  <= cfg_data[DWS-1:0];
        ddpm_pkg::CFG_PWM_UPPER:      upper_r    <= cfg_data[DWS-1:0];
        ddpm_pkg::CFG_PWM_LOWER:      lower_r    <= cfg_data[DWS-1:0];
        ddpm_pkg::CFG_DEADZONE_LIMIT: deadzone_r <= cfg_data[ddpm_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // spans are settled long before an item reaches the multiplier
  always_comb begin
    up_diff = $signed({1'b0, upper_r}) - $signed({1'b0, neutral_r});
    dn_diff = $signed({1'b0, neutral_r}) - $signed({1'b0, lower_r});
    up_abs  = up_diff[DWS] ? (DWS+1)'(-up_diff) : (DWS+1)'(up_diff);
    dn_abs  = dn_diff[DWS] ? (DWS+1)'(-dn_diff) : (DWS+1)'(dn_diff);
  end

  always_ff @(posedge clk) begin
    up_mag_r <= ddpm_pkg::DUTY_W'(up_abs[DWS-1:0]);
    dn_mag_r <= ddpm_pkg::DUTY_W'(dn_abs[DWS-1:0]);
    up_neg_r <= up_diff[DWS];
    dn_neg_r <= dn_diff[DWS];
  end

  always_comb begin
    duty_cfg.neutral     = ddpm_pkg::DUTY_W'(neutral_r);
    duty_cfg.span_up_mag = up_mag_r;
    duty_cfg.span_up_neg = up_neg_r;
    duty_cfg.span_dn_mag = dn_mag_r;
    duty_cfg.span_dn_neg = dn_neg_r;
    duty_cfg.deadzone    = deadzone_r;
  end

endmodule

// File: hw/rtl/ddpm_mix.sv
// front of the pipeline: mix, magnitude/sign split, scale decision and divisor select
// depends on ddpm_pkg

module ddpm_mix #(
  parameter int FRACTION_BITS = 14,
  localparam int MW = (FRACTION_BITS + 1 > ddpm_pkg::SPEED_W) ?
                      FRACTION_BITS + 1 : ddpm_pkg::SPEED_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  ddpm_pkg::in_req_t    in_req,
  output logic                 out_v,
  output logic [1:0]           out_sign,
  output logic [1:0][MW-1:0]   out_mag,
  output logic [1:0][MW-1:0]   out_div
);

  localparam int SW = ddpm_pkg::SPEED_W;
  localparam logic [MW-1:0] ONE = MW'(1) << FRACTION_BITS;

  // stage a: raw left/right speeds
  logic                 a_v_r;
  logic                 a_kind_r;
  logic signed [SW-1:0] a_left_r;
  logic signed [SW-1:0] a_right_r;
  logic signed [SW-1:0] a_left_nxt;
  logic signed [SW-1:0] a_right_nxt;
  logic signed [SW-1:0] fv;
  logic signed [SW-1:0] sv;

  // stage b: sign and magnitude
  logic                 b_v_r;
  logic                 b_kind_r;
  logic [1:0]           b_sign_r;
  logic [1:0][SW-1:0]   b_mag_r;
  logic [1:0][SW-1:0]   b_mag_nxt;

  // stage c: numerator and divisor for each lane
  logic                 c_v_r;
  logic [1:0]           c_sign_r;
  logic [1:0][MW-1:0]   c_mag_r;
  logic [1:0][MW-1:0]   c_div_r;
  logic [1:0][MW-1:0]   c_mag_nxt;
  logic [1:0][MW-1:0]   c_div_nxt;
  logic [MW-1:0]        peak;
  logic                 scale;

  always_comb begin
    fv = SW'(in_req.first_value);
    sv = SW'(in_req.second_value);
    if (in_req.kind) begin
      a_left_nxt  = fv - sv;
      a_right_nxt = fv + sv;
    end else begin
      a_left_nxt  = fv;
      a_right_nxt = sv;
    end
  end

  always_comb begin
    b_mag_nxt[0] = a_left_r[SW-1]  ? SW'(-a_left_r)  : SW'(a_left_r);
    b_mag_nxt[1] = a_right_r[SW-1] ? SW'(-a_right_r) : SW'(a_right_r);
  end

  // scaled lanes divide by the peak magnitude, the rest divide by one after a clamp
  always_comb begin
    peak  = (b_mag_r[0] > b_mag_r[1]) ? MW'(b_mag_r[0]) : MW'(b_mag_r[1]);
    scale = b_kind_r && ((MW'(b_mag_r[0]) > ONE) || (MW'(b_mag_r[1]) > ONE));
    for (int j = 0; j < 2; j++) begin
      if (scale) begin
        c_mag_nxt[j] = MW'(b_mag_r[j]);
        c_div_nxt[j] = peak;
      end else begin
        c_mag_nxt[j] = (MW'(b_mag_r[j]) > ONE) ? ONE : MW'(b_mag_r[j]);
        c_div_nxt[j] = ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r  <= in_req.kind;
      a_left_r  <= a_left_nxt;
      a_right_r <= a_right_nxt;
      b_kind_r  <= a_kind_r;
      b_sign_r  <= {a_right_r[SW-1], a_left_r[SW-1]};
      b_mag_r   <= b_mag_nxt;
      c_sign_r  <= b_sign_r;
      c_mag_r   <= c_mag_nxt;
      c_div_r   <= c_div_nxt;
    end
  end

  assign out_v    = c_v_r;
  assign out_sign = c_sign_r;
  assign out_mag  = c_mag_r;
  assign out_div  = c_div_r;

endmodule

// File: hw/rtl/ddpm_div_pipe.sv
// pipelined restoring divider for both lanes, one quotient bit per stage
// computes mag * 2^FRACTION_BITS / div; depends on ddpm_pkg

module ddpm_div_pipe #(
  parameter int FRACTION_BITS = 14,
  localparam int MW = (FRACTION_BITS + 1 > ddpm_pkg::SPEED_W) ?
                      FRACTION_BITS + 1 : ddpm_pkg::SPEED_W,
  localparam int QW = FRACTION_BITS + 1,
  localparam int RW = MW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [1:0]           in_sign,
  input  logic [1:0][MW-1:0]   in_mag,
  input  logic [1:0][MW-1:0]   in_div,
  output logic                 out_v,
  output logic [1:0]           out_sign,
  output logic [1:0][QW-1:0]   out_q
);

  // index 0 is the input, index k+1 the registers of stage k
  logic                 v_s    [QW+1];
  logic [1:0]           sign_s [QW+1];
  logic [1:0][RW-1:0]   cur_s  [QW+1];
  logic [1:0][QW-1:0]   q_s    [QW+1];
  logic [1:0][MW-1:0]   d_s    [QW+1];

  assign v_s[0]    = in_v;
  assign sign_s[0] = in_sign;
  assign cur_s[0]  = {{1'b0, in_mag[1]}, {1'b0, in_mag[0]}};
  assign q_s[0]    = '0;
  assign d_s[0]    = in_div;

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic                 v_r;
    logic [1:0]           sign_r;
    logic [1:0][RW-1:0]   cur_r;
    logic [1:0][QW-1:0]   q_r;
    logic [1:0][MW-1:0]   d_r;
    logic [1:0][RW-1:0]   cur_nxt;
    logic [1:0][QW-1:0]   q_nxt;
    logic [1:0][RW-1:0]   diff;
    logic [1:0][MW-1:0]   rem;
    logic [1:0]           ge;

    // numerator never exceeds the divisor, so the remainder fits MW bits
    always_comb begin
      for (int j = 0; j < 2; j++) begin
        diff[j]             = cur_s[k][j] - {1'b0, d_s[k][j]};
        ge[j]               = cur_s[k][j] >= {1'b0, d_s[k][j]};
        rem[j]              = ge[j] ? diff[j][MW-1:0] : cur_s[k][j][MW-1:0];
        cur_nxt[j]          = {rem[j], 1'b0};
        q_nxt[j]            = q_s[k][j];
        q_nxt[j][QW-1-k]    = ge[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sign_r <= sign_s[k];
        cur_r  <= cur_nxt;
        q_r    <= q_nxt;
        d_r    <= d_s[k];
      end
    end

    assign v_s[k+1]    = v_r;
    assign sign_s[k+1] = sign_r;
    assign cur_s[k+1]  = cur_r;
    assign q_s[k+1]    = q_r;
    assign d_s[k+1]    = d_r;
  end

  assign out_v    = v_s[QW];
  assign out_sign = sign_s[QW];
  assign out_q    = q_s[QW];

endmodule

// File: hw/rtl/ddpm_duty.sv
// back of the pipeline: deadzone test, span multiply, then duty add/subtract
// depends on ddpm_pkg

module ddpm_duty #(
  parameter int DUTY_BITS     = 16,
  parameter int FRACTION_BITS = 14,
  localparam int QW = FRACTION_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [1:0]           in_sign,
  input  logic [1:0][QW-1:0]   in_q,
  input  ddpm_pkg::duty_cfg_t  duty_cfg,
  output logic                 out_v,
  output ddpm_pkg::out_rsp_t   out_rsp
);

  localparam int DW  = ddpm_pkg::DUTY_W;
  localparam int DWS = (DUTY_BITS < DW) ? DUTY_BITS : DW;
  localparam int PW  = QW + DW;
  localparam int CW  = (QW > ddpm_pkg::DZ_W) ? QW : ddpm_pkg::DZ_W;

  // stage m: product of speed magnitude and span magnitude
  logic                 m_v_r;
  logic [1:0][PW-1:0]   m_prod_r;
  logic [1:0]           m_neg_r;
  logic [1:0]           m_dz_r;
  logic [1:0][PW-1:0]   m_prod_nxt;
  logic [1:0]           m_neg_nxt;
  logic [1:0]           m_dz_nxt;
  logic [DW-1:0]        smag [2];

  // stage n: final duty
  logic                 n_v_r;
  ddpm_pkg::out_rsp_t   n_rsp_r;
  ddpm_pkg::out_rsp_t   n_rsp_nxt;
  logic [1:0][DW-1:0]   trunc_q;
  logic [1:0][DW:0]     duty;
  logic [1:0][DW-1:0]   duty_out;

  // zero speed falls into the forward branch, its product is zero either way
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      smag[j]       = in_sign[j] ? duty_cfg.span_dn_mag : duty_cfg.span_up_mag;
      m_neg_nxt[j]  = in_sign[j] ^ (in_sign[j] ? duty_cfg.span_dn_neg
                                               : duty_cfg.span_up_neg);
      m_prod_nxt[j] = PW'(in_q[j]) * PW'(smag[j]);
      m_dz_nxt[j]   = CW'(in_q[j]) < CW'(duty_cfg.deadzone);
    end
  end

  // product over one truncates toward zero since it is taken on magnitudes
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      trunc_q[j] = m_prod_r[j][FRACTION_BITS +: DW];
      if (m_dz_r[j]) begin
        duty[j] = {1'b0, duty_cfg.neutral};
      end else if (m_neg_r[j]) begin
        duty[j] = {1'b0, duty_cfg.neutral} - {1'b0, trunc_q[j]};
      end else begin
        duty[j] = {1'b0, duty_cfg.neutral} + {1'b0, trunc_q[j]};
      end
      duty_out[j] = DW'(duty[j][DWS-1:0]);
    end
    n_rsp_nxt.left_duty  = duty_out[0];
    n_rsp_nxt.right_duty = duty_out[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      n_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= in_v;
      n_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod_r <= m_prod_nxt;
      m_neg_r  <= m_neg_nxt;
      m_dz_r   <= m_dz_nxt;
      n_rsp_r  <= n_rsp_nxt;
    end
  end

  assign out_v   = n_v_r;
  assign out_rsp = n_rsp_r;

endmodule

// File: hw/rtl/differential_drive_pwm_mixer_core.sv
// top level of the differential drive pwm mixer: pipeline plus output register and skid
// depends on ddpm_pkg, ddpm_cfg_regs, ddpm_mix, ddpm_div_pipe, ddpm_duty
//
// usage:
//   in_valid/in_stall/in_data carry one command: kind 0 gives left/right speeds,
//   kind 1 a linear/angular pair, both signed with 2^FRACTION_BITS as full speed.
//   out_valid/out_stall/out_data return the left and right pwm duty for it.
//   a request moves at a clock edge with valid high and stall low.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the duty and deadzone registers;
//   cfg_ready is always high, write only while no command is in flight.
// timing:
//   one command per cycle sustained while in_stall stays low; the divider
//   resolves one quotient bit per pipeline stage.
// reset and stall:
//   synchronous reset empties the pipeline and loads the register defaults.
//   while out_stall holds a result, one more result lands in the skid register;
//   after that in_stall rises and the whole pipeline freezes in place.

module differential_drive_pwm_mixer_core #(
  parameter int DUTY_BITS     = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ddpm_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ddpm_pkg::out_rsp_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ddpm_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  logic [ddpm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int MW = (FRACTION_BITS + 1 > ddpm_pkg::SPEED_W) ?
                      FRACTION_BITS + 1 : ddpm_pkg::SPEED_W;
  localparam int QW = FRACTION_BITS + 1;

  ddpm_pkg::duty_cfg_t duty_cfg;

  logic                 en;
  logic                 mix_v;
  logic [1:0]           mix_sign;
  logic [1:0][MW-1:0]   mix_mag;
  logic [1:0][MW-1:0]   mix_div;
  logic                 div_v;
  logic [1:0]           div_sign;
  logic [1:0][QW-1:0]   div_q;
  logic                 e_v;
  ddpm_pkg::out_rsp_t   e_rsp;

  logic                 out_v_r;
  logic                 out_v_nxt;
  ddpm_pkg::out_rsp_t   out_r;
  ddpm_pkg::out_rsp_t   out_nxt;
  logic                 skid_v_r;
  logic                 skid_v_nxt;
  ddpm_pkg::out_rsp_t   skid_r;
  ddpm_pkg::out_rsp_t   skid_nxt;
  logic                 out_take;

  // the pipeline only moves while the skid register is free
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  ddpm_cfg_regs #(
    .DUTY_BITS (DUTY_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .duty_cfg  (duty_cfg)
  );

  ddpm_mix #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid),
    .in_req   (in_data),
    .out_v    (mix_v),
    .out_sign (mix_sign),
    .out_mag  (mix_mag),
    .out_div  (mix_div)
  );

  ddpm_div_pipe #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (mix_v),
    .in_sign  (mix_sign),
    .in_mag   (mix_mag),
    .in_div   (mix_div),
    .out_v    (div_v),
    .out_sign (div_sign),
    .out_q    (div_q)
  );

  ddpm_duty #(
    .DUTY_BITS     (DUTY_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (div_v),
    .in_sign  (div_sign),
    .in_q     (div_q),
    .duty_cfg (duty_cfg),
    .out_v    (e_v),
    .out_rsp  (e_rsp)
  );

  assign out_take = out_v_r && !out_stall;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (out_take) begin
      out_v_nxt = 1'b0;
    end
    if (skid_v_r) begin
      if (out_take) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (e_v) begin
      if (!out_v_r || out_take) begin
        out_v_nxt = 1'b1;
        out_nxt   = e_rsp;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = e_rsp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // the skid register only holds a result behind a waiting output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  // skid fills only when the output was blocked in the previous cycle
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall))
    else $error("skid register filled without a blocked output");

  // a held skid result is not dropped before the output register frees up
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_take) |=> (skid_v_r && $stable(skid_r)))
    else $error("skid result lost while output blocked");

  // a result leaving the pipeline into a blocked output is parked in the skid
  a_pipe_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (e_v && !skid_v_r && out_v_r && out_stall) |=> (skid_v_r && skid_r == $past(e_rsp)))
    else $error("pipeline result not captured by skid register");

endmodule
